/* sv/csp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_pkg
// Shared widths, codes and reset values for the clock-sweep page replacer.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int PAGE_W        = 31;
    localparam int ACT_W         = 2;
    localparam int STATUS_W      = 3;
    localparam int FIDX_W        = 4;
    localparam int USAGE_W       = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 5;
    localparam int FRAMES_DEFAULT = 16;

    // Request actions. The last code is not a valid action and only draws an
    // absent answer.
    localparam logic [ACT_W-1:0] ACT_FETCH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PIN     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UNPIN   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOAD   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PIN    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_USAGE     = 1'd1;

    localparam logic [CFG_DATA_W-1:0] RST_FRAMES_IN_USE = 5'd16;
    localparam logic [USAGE_W-1:0]    RST_MAX_USAGE     = 3'd5;

endpackage

/* sv/csp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_req_if / csp_rsp_if
// Valid/ready channels carrying requests into and results out of the replacer.
// ----------------------------------------------------------------------------
interface csp_req_if;
    logic                         valid;
    logic                         ready;
    logic [csp_pkg::ACT_W-1:0]    action;
    logic [csp_pkg::PAGE_W-1:0]   page_id;

    modport source (output valid, output action, output page_id, input ready);
    modport sink   (input valid, input action, input page_id, output ready);
endinterface

interface csp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [csp_pkg::STATUS_W-1:0]  status;
    logic [csp_pkg::FIDX_W-1:0]    frame_index;
    logic                          evicted_valid;
    logic [csp_pkg::PAGE_W-1:0]    evicted_page;

    modport source (output valid, output status, output frame_index,
                    output evicted_valid, output evicted_page, input ready);
    modport sink   (input valid, input status, input frame_index,
                    input evicted_valid, input evicted_page, output ready);
endinterface

/* sv/csp_page_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_page_mem
// Page-id store, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csp_page_mem #(
    parameter int FRAMES = csp_pkg::FRAMES_DEFAULT,
    parameter int IDX_W  = 4
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [IDX_W-1:0]           waddr,
    input  logic [csp_pkg::PAGE_W-1:0] wdata,
    input  logic [IDX_W-1:0]           raddr,
    output logic [csp_pkg::PAGE_W-1:0] rdata
);

    logic [csp_pkg::PAGE_W-1:0] mem [FRAMES];
    logic [csp_pkg::PAGE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/clock_sweep_page_replacer.sv */
`timescale 1ns / 1ps
// Steps: accept, then search the frames in order from frame 0 (stopping at a hit, or at the
// end of the pool on a miss), then on a fetch miss a sweep of at most two turns of the pool,
// then the output register.
// One request at a time; the next is taken once the previous result is in the output register.
// The page search and the sweep share one frame pointer and the single page-store read port.
// Reset clears all frame flags, usage counts and the hand; page ids are not cleared.
// ----------------------------------------------------------------------------
// clock_sweep_page_replacer
// Buffer-pool frame manager with clock-sweep victim selection.
// ----------------------------------------------------------------------------
module clock_sweep_page_replacer #(
    parameter int FRAMES = csp_pkg::FRAMES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    csp_req_if.sink                         req,
    csp_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int STEP_W = IDX_W + 1;
    localparam int UW     = csp_pkg::USAGE_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [csp_pkg::ACT_W-1:0]        act_reg, act_next;
    logic [csp_pkg::PAGE_W-1:0]       page_reg, page_next;
    logic [IDX_W-1:0]                 ptr_reg, ptr_next;
    logic [IDX_W-1:0]                 hand_reg, hand_next;
    logic [STEP_W-1:0]                step_reg, step_next;
    logic [csp_pkg::CFG_DATA_W-1:0]   cfg_frames_reg;
    logic [UW-1:0]                    cfg_usage_reg;

    logic                             valid_reg  [FRAMES];
    logic [UW-1:0]                    usage_reg  [FRAMES];
    logic                             pinned_reg [FRAMES];

    logic [csp_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [IDX_W-1:0]                 res_fidx_reg, res_fidx_next;
    logic                             res_ev_valid_reg, res_ev_valid_next;
    logic [csp_pkg::PAGE_W-1:0]       res_ev_page_reg, res_ev_page_next;

    logic                             out_valid_reg, out_valid_next;
    logic [csp_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [IDX_W-1:0]                 out_fidx_reg, out_fidx_next;
    logic                             out_ev_valid_reg, out_ev_valid_next;
    logic [csp_pkg::PAGE_W-1:0]       out_ev_page_reg, out_ev_page_next;

    logic [csp_pkg::PAGE_W-1:0]       rd_page;
    logic                             mem_we;
    logic                             upd_usage, upd_pin, set_valid;
    logic [UW-1:0]                    usage_new;
    logic                             pin_new;

    logic [31:0]                      last32;
    logic [IDX_W-1:0]                 pool_last;
    logic [UW-1:0]                    usage_lim;
    logic [UW:0]                      usage_inc;
    logic                             cur_valid, cur_pinned, page_match;
    logic [UW-1:0]                    cur_usage;
    logic [IDX_W-1:0]                 ptr_inc, hand_start;

    csp_page_mem #(
        .FRAMES (FRAMES),
        .IDX_W  (IDX_W)
    ) u_page_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ptr_reg),
        .wdata (page_reg),
        .raddr (ptr_next),
        .rdata (rd_page)
    );

    // Effective pool size minus one, with zero and oversize settings clamped.
    always_comb
    begin
        if (cfg_frames_reg == '0)
        begin
            last32 = 32'd0;
        end
        else if (32'(cfg_frames_reg) > 32'(FRAMES))
        begin
            last32 = 32'(FRAMES - 1);
        end
        else
        begin
            last32 = 32'(cfg_frames_reg) - 32'd1;
        end
    end

    assign pool_last  = last32[IDX_W-1:0];
    assign usage_lim  = (cfg_usage_reg == '0) ? UW'(1) : cfg_usage_reg;
    assign cur_valid  = valid_reg[ptr_reg];
    assign cur_pinned = pinned_reg[ptr_reg];
    assign cur_usage  = usage_reg[ptr_reg];
    assign usage_inc  = {1'b0, cur_usage} + 1'b1;
    assign page_match = cur_valid && (rd_page == page_reg);
    assign ptr_inc    = (ptr_reg == pool_last) ? '0 : IDX_W'(ptr_reg + 1'b1);
    assign hand_start = (hand_reg > pool_last) ? '0 : hand_reg;

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.frame_index   = csp_pkg::FIDX_W'(out_fidx_reg);
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;

    always_comb
    begin
        state_next        = state_reg;
        act_next          = act_reg;
        page_next         = page_reg;
        ptr_next          = ptr_reg;
        hand_next         = hand_reg;
        step_next         = step_reg;
        res_status_next   = res_status_reg;
        res_fidx_next     = res_fidx_reg;
        res_ev_valid_next = res_ev_valid_reg;
        res_ev_page_next  = res_ev_page_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_status_next   = out_status_reg;
        out_fidx_next     = out_fidx_reg;
        out_ev_valid_next = out_ev_valid_reg;
        out_ev_page_next  = out_ev_page_reg;
        mem_we            = 1'b0;
        upd_usage         = 1'b0;
        upd_pin           = 1'b0;
        set_valid         = 1'b0;
        usage_new         = cur_usage;
        pin_new           = cur_pinned;

        unique case (state_reg)
            S_IDLE:
            begin
                ptr_next = '0;
                if (req.valid)
                begin
                    act_next   = req.action;
                    page_next  = req.page_id;
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                res_fidx_next     = '0;
                res_ev_valid_next = 1'b0;
                res_ev_page_next  = '0;
                res_status_next   = csp_pkg::ST_ABSENT;
                if (page_match)
                begin
                    state_next = S_DONE;
                    priority if (act_reg == csp_pkg::ACT_FETCH)
                    begin
                        upd_usage       = 1'b1;
                        usage_new       = (usage_inc < {1'b0, usage_lim}) ?
                                          usage_inc[UW-1:0] : usage_lim;
                        res_status_next = csp_pkg::ST_HIT;
                        res_fidx_next   = ptr_reg;
                    end
                    else if (act_reg == csp_pkg::ACT_PIN || act_reg == csp_pkg::ACT_UNPIN)
                    begin
                        upd_pin         = 1'b1;
                        pin_new         = (act_reg == csp_pkg::ACT_PIN);
                        res_status_next = csp_pkg::ST_PIN;
                    end
                    else
                    begin
                        res_status_next = csp_pkg::ST_ABSENT;
                    end
                end
                else if (ptr_reg == pool_last)
                begin
                    if (act_reg == csp_pkg::ACT_FETCH)
                    begin
                        ptr_next   = hand_start;
                        step_next  = '0;
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ptr_next = IDX_W'(ptr_reg + 1'b1);
                end
            end

            S_SWEEP:
            begin
                // The hand always moves past the frame it looks at, victim or not.
                hand_next = ptr_inc;
                if (!cur_pinned && (!cur_valid || cur_usage == '0))
                begin
                    mem_we            = 1'b1;
                    set_valid         = 1'b1;
                    upd_usage         = 1'b1;
                    usage_new         = UW'(1);
                    upd_pin           = 1'b1;
                    pin_new           = 1'b0;
                    res_status_next   = csp_pkg::ST_LOAD;
                    res_fidx_next     = ptr_reg;
                    res_ev_valid_next = cur_valid;
                    res_ev_page_next  = cur_valid ? rd_page : '0;
                    state_next        = S_DONE;
                end
                else
                begin
                    if (!cur_pinned)
                    begin
                        upd_usage = 1'b1;
                        usage_new = cur_usage - 1'b1;
                    end
                    if (step_reg == {pool_last, 1'b1})
                    begin
                        res_status_next = csp_pkg::ST_FAIL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                        ptr_next  = ptr_inc;
                    end
                end
            end

            S_DONE:
            begin
                ptr_next = '0;
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = res_status_reg;
                    out_fidx_next     = res_fidx_reg;
                    out_ev_valid_next = res_ev_valid_reg;
                    out_ev_page_next  = res_ev_page_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hand_reg       <= '0;
            out_valid_reg  <= 1'b0;
            cfg_frames_reg <= csp_pkg::RST_FRAMES_IN_USE;
            cfg_usage_reg  <= csp_pkg::RST_MAX_USAGE;
            for (int i = 0; i < FRAMES; i++)
            begin
                valid_reg[i]  <= 1'b0;
                usage_reg[i]  <= '0;
                pinned_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == csp_pkg::CFG_FRAMES_IN_USE)
                begin
                    cfg_frames_reg <= cfg_wdata;
                end
                else
                begin
                    cfg_usage_reg <= cfg_wdata[UW-1:0];
                end
            end
            if (set_valid)
            begin
                valid_reg[ptr_reg] <= 1'b1;
            end
            if (upd_usage)
            begin
                usage_reg[ptr_reg] <= usage_new;
            end
            if (upd_pin)
            begin
                pinned_reg[ptr_reg] <= pin_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg          <= act_next;
        page_reg         <= page_next;
        ptr_reg          <= ptr_next;
        step_reg         <= step_next;
        res_status_reg   <= res_status_next;
        res_fidx_reg     <= res_fidx_next;
        res_ev_valid_reg <= res_ev_valid_next;
        res_ev_page_reg  <= res_ev_page_next;
        out_status_reg   <= out_status_next;
        out_fidx_reg     <= out_fidx_next;
        out_ev_valid_reg <= out_ev_valid_next;
        out_ev_page_reg  <= out_ev_page_next;
    end

endmodule

/* sim/csp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_checker
// Passive checker for the clock-sweep page replacer. It watches the request,
// result and register ports, keeps its own copy of the frame table, hand and
// registers, predicts the result of every accepted request and compares each
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module csp_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    csp_req_if                             req,
    csp_rsp_if                             rsp,
    input  logic                           cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             outstanding,
    output int                             status_tally [5]
);

    localparam int FRAMES = csp_pkg::FRAMES_DEFAULT;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [csp_pkg::STATUS_W-1:0] status;
        logic [csp_pkg::FIDX_W-1:0]   frame_index;
        logic                         evicted_valid;
        logic [csp_pkg::PAGE_W-1:0]   evicted_page;
    } frame_result_t;

    logic [csp_pkg::PAGE_W-1:0]     page_of   [FRAMES];
    logic                           valid_of  [FRAMES];
    logic [csp_pkg::USAGE_W-1:0]    usage_of  [FRAMES];
    logic                           pinned_of [FRAMES];
    logic [csp_pkg::FIDX_W-1:0]     hand;
    logic [csp_pkg::CFG_DATA_W-1:0] frames_reg;
    logic [csp_pkg::USAGE_W-1:0]    usage_cap_reg;

    frame_result_t pending_results [$];

    function automatic int active_frames();
        if (frames_reg == 0)
        begin
            return 1;
        end
        if (frames_reg > FRAMES)
        begin
            return FRAMES;
        end
        return int'(frames_reg);
    endfunction

    // Applies one request to the predicted frame table and returns its result.
    function automatic frame_result_t resolve_request(
        input logic [csp_pkg::ACT_W-1:0]  act,
        input logic [csp_pkg::PAGE_W-1:0] page);
        frame_result_t r;
        int n;
        int i;
        int found;
        int victim;
        int step;
        int h;
        int u;
        int lim;
        r        = '0;
        r.status = csp_pkg::ST_ABSENT;
        n        = active_frames();
        found    = -1;
        // Scan downward so that the lowest matching frame wins.
        for (i = n - 1; i >= 0; i--)
        begin
            if (valid_of[i] && page_of[i] == page)
            begin
                found = i;
            end
        end
        if (act == csp_pkg::ACT_FETCH)
        begin
            if (found >= 0)
            begin
                lim = (usage_cap_reg == 0) ? 1 : int'(usage_cap_reg);
                u   = int'(usage_of[found]) + 1;
                usage_of[found] = csp_pkg::USAGE_W'((u < lim) ? u : lim);
                r.status        = csp_pkg::ST_HIT;
                r.frame_index   = csp_pkg::FIDX_W'(found);
            end
            else
            begin
                victim = -1;
                if (int'(hand) >= n)
                begin
                    hand = '0;
                end
                for (step = 0; step < 2 * n && victim < 0; step++)
                begin
                    h    = int'(hand);
                    hand = csp_pkg::FIDX_W'((h + 1) % n);
                    if (!pinned_of[h])
                    begin
                        if (!valid_of[h] || usage_of[h] == 0)
                        begin
                            victim = h;
                        end
                        else
                        begin
                            usage_of[h] = usage_of[h] - 1'b1;
                        end
                    end
                end
                if (victim < 0)
                begin
                    r.status = csp_pkg::ST_FAIL;
                end
                else
                begin
                    if (valid_of[victim])
                    begin
                        r.evicted_valid = 1'b1;
                        r.evicted_page  = page_of[victim];
                    end
                    page_of[victim]   = page;
                    valid_of[victim]  = 1'b1;
                    usage_of[victim]  = csp_pkg::USAGE_W'(1);
                    pinned_of[victim] = 1'b0;
                    r.status          = csp_pkg::ST_LOAD;
                    r.frame_index     = csp_pkg::FIDX_W'(victim);
                end
            end
        end
        else if (act == csp_pkg::ACT_PIN || act == csp_pkg::ACT_UNPIN)
        begin
            if (found >= 0)
            begin
                pinned_of[found] = (act == csp_pkg::ACT_PIN);
                r.status         = csp_pkg::ST_PIN;
            end
        end
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_result();
        frame_result_t got;
        frame_result_t want;
        got = {rsp.status, rsp.frame_index, rsp.evicted_valid, rsp.evicted_page};
        if (got.status <= csp_pkg::ST_ABSENT)
        begin
            status_tally[got.status]++;
        end
        if (pending_results.size() == 0)
        begin
            log_mismatch($sformatf("unexpected result beat: status %0d frame %0d evicted %0b/%h",
                                   got.status, got.frame_index, got.evicted_valid,
                                   got.evicted_page));
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.frame_index !== want.frame_index ||
                got.evicted_valid !== want.evicted_valid ||
                got.evicted_page !== want.evicted_page)
            begin
                log_mismatch($sformatf({"result mismatch (expected/actual): status %0d/%0d ",
                                        "frame %0d/%0d evicted %0b/%0b page %h/%h"},
                                       want.status, got.status,
                                       want.frame_index, got.frame_index,
                                       want.evicted_valid, got.evicted_valid,
                                       want.evicted_page, got.evicted_page));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                valid_of[i]  = 1'b0;
                usage_of[i]  = '0;
                pinned_of[i] = 1'b0;
            end
            for (int i = 0; i < 5; i++)
            begin
                status_tally[i] = 0;
            end
            hand          = '0;
            frames_reg    = csp_pkg::RST_FRAMES_IN_USE;
            usage_cap_reg = csp_pkg::RST_MAX_USAGE;
            pending_results.delete();
            fail_count    = 0;
            outstanding   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    csp_pkg::CFG_FRAMES_IN_USE: frames_reg    = cfg_wdata;
                    csp_pkg::CFG_MAX_USAGE:     usage_cap_reg = cfg_wdata[csp_pkg::USAGE_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                check_result();
            end
            if (req.valid && req.ready)
            begin
                pending_results.push_back(resolve_request(req.action, req.page_id));
            end
            outstanding = pending_results.size();
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the clock-sweep page replacer. A directed opening
// walks through hits, loads, evictions, pins, sweep failure, odd actions and
// out-of-range register values; random phases then mix fetches, pin changes
// and invalid actions over a small page working set under several register
// settings and idle/stall patterns. Checking is done by csp_checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RSP_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 60;
    localparam int WORKING_PAGES   = 24;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [csp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [csp_pkg::CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int outstanding;
    int status_tally [5];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_ask;
    int hold_seen = 0;
    int hold_left = 0;
    int requests_sent;
    int settings_written;

    logic [csp_pkg::PAGE_W-1:0] working_set [WORKING_PAGES];

    csp_req_if req_ch ();
    csp_rsp_if rsp_ch ();

    clock_sweep_page_replacer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    csp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .status_tally (status_tally)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Result-side ready. A long hold-off is requested by bumping hold_ask.
    always @(posedge clk)
    begin
        if (hold_ask != hold_seen)
        begin
            hold_seen = hold_ask;
            hold_left = RSP_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_request(input logic [csp_pkg::ACT_W-1:0] act,
                                input logic [csp_pkg::PAGE_W-1:0] page);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.page_id <= page;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    // Lowers valid, then waits until every predicted result has been taken.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_config(input int frames, input int usage_cap);
        cfg_we    <= 1'b1;
        cfg_index <= csp_pkg::CFG_FRAMES_IN_USE;
        cfg_wdata <= csp_pkg::CFG_DATA_W'(frames);
        @(posedge clk);
        cfg_index <= csp_pkg::CFG_MAX_USAGE;
        cfg_wdata <= csp_pkg::CFG_DATA_W'(usage_cap);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    task automatic reconfigure(input int frames, input int usage_cap);
        drain_results();
        write_config(frames, usage_cap);
    endtask

    task automatic run_phase(input int count, input int frames, input int usage_cap,
                             input int snd_pct, input int rcv_pct, input bit pressure);
        logic [csp_pkg::ACT_W-1:0]  act;
        logic [csp_pkg::PAGE_W-1:0] page;
        int pick;
        reconfigure(frames, usage_cap);
        sender_idle_pct    = snd_pct;
        receiver_stall_pct = rcv_pct;
        for (int k = 0; k < count; k++)
        begin
            if (pressure && k == count / 3)
            begin
                // Results back up; the sender keeps offering until the block stalls it.
                hold_ask++;
            end
            if (pressure && k == 2 * count / 3)
            begin
                drain_results();
            end
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                act = csp_pkg::ACT_FETCH;
            end
            else if (pick < 78)
            begin
                act = csp_pkg::ACT_PIN;
            end
            else if (pick < 94)
            begin
                act = csp_pkg::ACT_UNPIN;
            end
            else
            begin
                act = csp_pkg::ACT_UNKNOWN;
            end
            if ($urandom_range(15) == 0)
            begin
                page = csp_pkg::PAGE_W'($urandom);
            end
            else
            begin
                page = working_set[$urandom_range(WORKING_PAGES - 1)];
            end
            send_request(act, page);
        end
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [csp_pkg::PAGE_W-1:0] pg [8];
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = csp_pkg::ACT_FETCH;
        req_ch.page_id     = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_ask           = 0;
        requests_sent      = 0;
        settings_written   = 0;
        for (int i = 0; i < WORKING_PAGES; i++)
        begin
            working_set[i] = csp_pkg::PAGE_W'($urandom);
        end
        pg[0] = '1;
        pg[1] = '0;
        pg[2] = 31'h2AAA_AAAA;
        pg[3] = 31'h5555_5555;
        for (int i = 4; i < 8; i++)
        begin
            pg[i] = csp_pkg::PAGE_W'($urandom);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill a four-frame pool, saturate one usage count, then pin every frame
        // so that the next miss sweeps twice around without a victim.
        write_config(4, 2);
        for (int i = 0; i < 4; i++)
        begin
            send_request(csp_pkg::ACT_FETCH, pg[i]);
        end
        send_request(csp_pkg::ACT_FETCH, pg[0]);
        send_request(csp_pkg::ACT_FETCH, pg[0]);
        for (int i = 0; i < 4; i++)
        begin
            send_request(csp_pkg::ACT_PIN, pg[i]);
        end
        send_request(csp_pkg::ACT_FETCH, pg[4]);
        send_request(csp_pkg::ACT_UNPIN, pg[1]);
        send_request(csp_pkg::ACT_UNPIN, pg[5]);
        send_request(csp_pkg::ACT_UNKNOWN, pg[0]);
        send_request(csp_pkg::ACT_FETCH, pg[4]);

        // Shrink the pool so the hand lies beyond it, load a page that is still
        // held in a frame outside the pool, then grow back to expose two copies.
        reconfigure(2, 0);
        send_request(csp_pkg::ACT_FETCH, pg[3]);
        reconfigure(4, 7);
        send_request(csp_pkg::ACT_FETCH, pg[3]);
        send_request(csp_pkg::ACT_FETCH, pg[3]);

        // Register values outside the nominal range.
        reconfigure(0, 3);
        send_request(csp_pkg::ACT_FETCH, pg[5]);
        send_request(csp_pkg::ACT_FETCH, pg[6]);
        reconfigure(31, 1);
        send_request(csp_pkg::ACT_FETCH, pg[7]);
        send_request(csp_pkg::ACT_FETCH, pg[7]);
        req_ch.valid <= 1'b0;

        run_phase(130, 16, 5,  0,  0, 1'b0);
        run_phase(130,  1, 1,  0,  0, 1'b0);
        run_phase(130,  4, 7, 86,  0, 1'b0);
        run_phase(130,  0, 0,  0, 86, 1'b0);
        run_phase(130, 31, 3, 12, 12, 1'b0);
        run_phase(130,  8, 2,  0,  0, 1'b1);
        run_phase(130, 17, 7, 86,  0, 1'b0);
        run_phase(130,  2, 4,  0, 86, 1'b0);
        run_phase(130, 12, 6, 12, 12, 1'b0);
        run_phase(130, 16, 1,  0,  0, 1'b0);
        run_phase(130,  3, 7, 86,  0, 1'b0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests across %0d register settings and four idle/stall modes.",
                 requests_sent, settings_written);
        $display("Results seen: hit %0d, load %0d, no victim %0d, pin change %0d, absent %0d.",
                 status_tally[csp_pkg::ST_HIT], status_tally[csp_pkg::ST_LOAD],
                 status_tally[csp_pkg::ST_FAIL], status_tally[csp_pkg::ST_PIN],
                 status_tally[csp_pkg::ST_ABSENT]);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
